/* sv/sliding_window_minimum_top_macros.svh */
// Assertion macros for the sliding window minimum block.
`ifndef SLIDING_WINDOW_MINIMUM_TOP_MACROS_SVH
`define SLIDING_WINDOW_MINIMUM_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/swm_pkg.sv */
// Package: shared constants and types of the sliding window minimum block.
`default_nettype none
package swm_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int WL_W            = 7;
  localparam logic [WL_W-1:0] WL_RESET = WL_W'(1);

  // Control part of the search token that walks down the cell chain.
  typedef struct packed {
    logic vld;
    logic have;
  } tok_ctl_t;

endpackage
`default_nettype wire

/* sv/swm_if.sv */
// Interfaces: sample request, result request and configuration write channels.
`default_nettype none
interface swm_in_if #(
  parameter int SampleBits = swm_pkg::SAMPLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;
  logic                         start_new;

  modport source (output valid, output sample, output start_new, input ready);
  modport sink   (input valid, input sample, input start_new, output ready);
endinterface

interface swm_out_if #(
  parameter int SampleBits = swm_pkg::SAMPLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] window_min;
  logic                         had_history;

  modport source (output valid, output window_min, output had_history, input ready);
  modport sink   (input valid, input window_min, input had_history, output ready);
endinterface

interface swm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [swm_pkg::WL_W-1:0]  window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface
`default_nettype wire

/* sv/sliding_window_minimum_top.sv */
// Top level: sliding window minimum over a signed sample stream, cell chain search.
// The search token walks every cell in turn, then the result is registered at the output.
// A new request is taken only once the previous result has left the sequencer, so
// input also stalls while a search is in flight and while a second finished result waits.
// Reset (rst_ni low, asynchronous): history count cleared, window_length back to 1,
// no result pending. History cells are not cleared; entries are read only once written.
`default_nettype none
`include "sliding_window_minimum_top_macros.svh"
module sliding_window_minimum_top #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  swm_in_if.sink    in_i,
  swm_out_if.source out_o,
  swm_cfg_if.sink   cfg_i
);
  import swm_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int LEN_W = (CNT_W > WL_W) ? CNT_W : WL_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_e;

  state_e                        state_q;
  logic [WL_W-1:0]               wlen_q;
  logic [CNT_W-1:0]              count_q;
  logic [CNT_W-1:0]              span_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] pend_min_q;
  logic                          pend_have_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_min_q;
  logic                          out_have_q;

  logic                          in_acc;
  logic                          out_free;
  logic                          out_load;
  logic                          tok_exit;
  logic [LEN_W-1:0]              wlen_ext;
  logic [CNT_W-1:0]              eff_len;
  logic [CNT_W-1:0]              cnt_base;
  logic [CNT_W-1:0]              span_d;
  logic [CNT_W-1:0]              span_w;

  // Chain wiring: index k is the output of cell k.
  logic signed [SAMPLE_BITS-1:0] data_w [WINDOW_MAX];
  tok_ctl_t                      tok_w  [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] min_w  [WINDOW_MAX];
  tok_ctl_t                      tok_head;

  // Configuration: always ready, single register.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WL_RESET;
    end else if (cfg_i.valid) begin
      wlen_q <= cfg_i.window_length;
    end
  end

  // Accept a new request only while no search is in flight or waiting.
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign tok_exit   = tok_w[WINDOW_MAX-1].vld;

  // Load the output register when a finished search can leave the sequencer.
  assign out_load = out_free && (((state_q == S_RUN) && tok_exit) || (state_q == S_HOLD));

  // Saturate the window length into 1..WINDOW_MAX.
  always_comb begin
    wlen_ext = LEN_W'(wlen_q);
    if (wlen_ext == '0) begin
      eff_len = CNT_W'(1);
    end else if (wlen_ext > LEN_W'(WINDOW_MAX)) begin
      eff_len = CNT_W'(WINDOW_MAX);
    end else begin
      eff_len = wlen_ext[CNT_W-1:0];
    end
  end

  // A start flag drops the history before this request is searched.
  assign cnt_base = in_i.start_new ? '0 : count_q;
  assign span_d   = (eff_len < cnt_base) ? eff_len : cnt_base;

  // Cell 0 folds on the accepting edge, before span_q holds the new span.
  assign span_w = in_acc ? span_d : span_q;

  // Launch a fresh token into cell 0 on the accepting edge.
  always_comb begin
    tok_head.vld  = in_acc;
    tok_head.have = 1'b0;
  end

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    swm_cell #(
      .WINDOW_MAX (WINDOW_MAX),
      .SAMPLE_BITS(SAMPLE_BITS),
      .IDX        (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(tok_exit),
      .data_i ((k == 0) ? sample_q : data_w[(k == 0) ? 0 : k - 1]),
      .data_o (data_w[k]),
      .span_i (span_w),
      .tok_i  ((k == 0) ? tok_head : tok_w[(k == 0) ? 0 : k - 1]),
      .min_i  ((k == 0) ? '0 : min_w[(k == 0) ? 0 : k - 1]),
      .tok_o  (tok_w[k]),
      .min_o  (min_w[k])
    );
  end

  // Sequencer: latch the request, wait for the token to leave the last cell,
  // then advance the history and hand the result to the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      span_q      <= '0;
      sample_q    <= '0;
      pend_min_q  <= '0;
      pend_have_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_min_q   <= '0;
      out_have_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            span_q   <= span_d;
            count_q  <= cnt_base;
            sample_q <= in_i.sample;
            state_q  <= S_RUN;
          end
        end
        S_RUN: begin
          if (tok_exit) begin
            // The new sample enters cell 0 this edge; saturate the count.
            if (count_q != CNT_W'(WINDOW_MAX)) begin
              count_q <= count_q + CNT_W'(1);
            end
            if (out_free) begin
              out_have_q  <= tok_w[WINDOW_MAX-1].have;
              out_min_q   <= tok_w[WINDOW_MAX-1].have ? min_w[WINDOW_MAX-1] : '0;
              state_q     <= S_IDLE;
            end else begin
              pend_have_q <= tok_w[WINDOW_MAX-1].have;
              pend_min_q  <= tok_w[WINDOW_MAX-1].have ? min_w[WINDOW_MAX-1] : '0;
              state_q     <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_have_q  <= pend_have_q;
            out_min_q   <= pend_min_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.window_min  = out_min_q;
  assign out_o.had_history = out_have_q;

  `SWM_ASSERT_NOW(a_exit_in_run, tok_exit, state_q == S_RUN, "token left chain outside search")
  `SWM_ASSERT_NEXT(a_acc_runs, in_acc, (state_q == S_RUN) && !in_i.ready, "request not latched")
  `SWM_ASSERT_NOW(a_ready_no_token, in_i.ready, !tok_exit, "ready while a search is in flight")
  `SWM_ASSERT_NOW(a_empty_zero, out_valid_q && !out_have_q, out_min_q == '0, "empty result nonzero")
  `SWM_ASSERT_NOW(a_span_bound, state_q == S_RUN, span_q <= count_q, "span exceeds history")

endmodule
`default_nettype wire

/* sv/swm_cell.sv */
// One history cell: holds a sample and folds it into the passing search token.
`default_nettype none
module swm_cell #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
  parameter int IDX         = 0,
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1)
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          shift_i,
  input  wire signed [SAMPLE_BITS-1:0] data_i,
  output logic signed [SAMPLE_BITS-1:0] data_o,
  input  wire [CNT_W-1:0]              span_i,
  input  swm_pkg::tok_ctl_t            tok_i,
  input  wire signed [SAMPLE_BITS-1:0] min_i,
  output swm_pkg::tok_ctl_t            tok_o,
  output logic signed [SAMPLE_BITS-1:0] min_o
);
  import swm_pkg::*;

  logic signed [SAMPLE_BITS-1:0] data_q;
  tok_ctl_t                      tok_q, tok_d;
  logic signed [SAMPLE_BITS-1:0] min_q, min_d;
  logic                          take;

  assign take = (CNT_W'(IDX) < span_i) && (!tok_i.have || (data_q < min_i));

  always_comb begin
    tok_d.vld  = tok_i.vld;
    tok_d.have = tok_i.have || take;
    min_d      = take ? data_q : min_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q <= min_d;
    if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;
  assign tok_o  = tok_q;
  assign min_o  = min_q;
endmodule
`default_nettype wire
